### src/linear_key_value_table_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear key/value table
// Shared property forms, clocked on aclk and held off during reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_KEY_VALUE_TABLE_DEFINES_SVH
`define LINEAR_KEY_VALUE_TABLE_DEFINES_SVH

// same-cycle implication
`define LKV_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("lkv assertion failed");

// next-cycle implication
`define LKV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("lkv assertion failed");

// condition that must never hold
`define LKV_ASSERT_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("lkv assertion failed");

`endif

### src/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Request/response types, command codes and controller types for the table.
// ----------------------------------------------------------------------------
package lkv_pkg;

    localparam logic [2:0] CMD_PUT        = 3'd0;
    localparam logic [2:0] CMD_GET        = 3'd1;
    localparam logic [2:0] CMD_REMOVE     = 3'd2;
    localparam logic [2:0] CMD_READ_INDEX = 3'd3;
    localparam logic [2:0] CMD_MIN_KEY    = 3'd4;
    localparam logic [2:0] CMD_CLEAR      = 3'd5;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [63:0] key;
        logic [63:0]        value;
        logic [7:0]         index;
    } req_t;

    typedef struct packed {
        logic               found;
        logic [63:0]        value_out;
        logic signed [63:0] key_out;
        logic [8:0]         entry_count;
        logic               status;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_RDIDX,
        ST_RDWAIT,
        ST_FINISH
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic latch;
        logic clear_count;
        logic seq_run;
        logic take_hit;
        logic min_run;
        logic put_update;
        logic append;
        logic set_full;
        logic shift_start;
        logic shift_write;
        logic dec_count;
        logic rd_index;
        logic capture_idx;
        logic result_load;
    } ctrl_t;

    // datapath -> controller
    typedef struct packed {
        logic match;
        logic seq_end;
        logic full;
    } stat_t;

endpackage

### src/lkv_datapath.sv
// ----------------------------------------------------------------------------
// lkv_datapath
// Key and value RAMs, entry count, scan pointer, min tracker and result register.
// ----------------------------------------------------------------------------
`include "linear_key_value_table_defines.svh"

module lkv_datapath #(
    parameter int CAPACITY = 256
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  lkv_pkg::req_t  s_req,
    input  lkv_pkg::ctrl_t ctrl,
    output lkv_pkg::stat_t stat,
    output lkv_pkg::rsp_t  m_rsp
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [63:0] key_mem [CAPACITY];
    logic [63:0]        val_mem [CAPACITY];

    logic signed [63:0] rd_key_reg;
    logic [63:0]        rd_val_reg;
    logic [AW-1:0]      rd_addr;

    logic               key_we, val_we;
    logic [AW-1:0]      wr_addr;
    logic signed [63:0] wr_key;
    logic [63:0]        wr_val;

    lkv_pkg::req_t      req_reg, req_next;
    lkv_pkg::rsp_t      rsp_reg, rsp_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      ptr_reg, ptr_next;
    logic               pend_reg, pend_next;
    logic [AW-1:0]      pend_idx_reg, pend_idx_next;
    logic               hit_reg, hit_next;
    logic [63:0]        hit_val_reg, hit_val_next;
    logic signed [63:0] min_reg, min_next;
    logic               min_valid_reg, min_valid_next;
    logic               status_reg, status_next;

    logic issue;
    logic match;
    logic index_ok;

    always_comb begin
        issue    = ptr_reg < count_reg;
        match    = pend_reg && (rd_key_reg == req_reg.key);
        index_ok = 32'(req_reg.index) < 32'(count_reg);

        stat.match    = match;
        stat.seq_end  = !pend_reg && !issue;
        stat.full     = count_reg >= CW'(CAPACITY);

        rd_addr = ctrl.rd_index ? AW'(req_reg.index) : AW'(ptr_reg);
    end

    // single write port shared by shift, update and append
    always_comb begin
        key_we  = 1'b0;
        val_we  = 1'b0;
        wr_addr = AW'(count_reg);
        wr_key  = req_reg.key;
        wr_val  = req_reg.value;
        priority if (ctrl.shift_write && pend_reg) begin
            key_we  = 1'b1;
            val_we  = 1'b1;
            wr_addr = pend_idx_reg - AW'(1);
            wr_key  = rd_key_reg;
            wr_val  = rd_val_reg;
        end else if (ctrl.put_update) begin
            val_we  = 1'b1;
            wr_addr = pend_idx_reg;
        end else if (ctrl.append) begin
            key_we  = 1'b1;
            val_we  = 1'b1;
        end else begin
            key_we  = 1'b0;
            val_we  = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (key_we) begin
            key_mem[wr_addr] <= wr_key;
        end
        if (val_we) begin
            val_mem[wr_addr] <= wr_val;
        end
        rd_key_reg <= key_mem[rd_addr];
        rd_val_reg <= val_mem[rd_addr];
    end

    always_comb begin
        req_next       = req_reg;
        rsp_next       = rsp_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        hit_next       = hit_reg;
        hit_val_next   = hit_val_reg;
        min_next       = min_reg;
        min_valid_next = min_valid_reg;
        status_next    = status_reg;

        if (ctrl.latch) begin
            req_next       = s_req;
            ptr_next       = '0;
            pend_next      = 1'b0;
            hit_next       = 1'b0;
            hit_val_next   = '0;
            min_valid_next = 1'b0;
            status_next    = 1'b0;
        end else begin
            if (ctrl.seq_run) begin
                pend_next     = issue;
                pend_idx_next = AW'(ptr_reg);
                if (issue) begin
                    ptr_next = ptr_reg + CW'(1);
                end
            end
            // remove: restart the pointer just past the hit
            if (ctrl.shift_start) begin
                ptr_next  = CW'(pend_idx_reg) + CW'(1);
                pend_next = 1'b0;
            end
            if (ctrl.take_hit && match) begin
                hit_next     = 1'b1;
                hit_val_next = rd_val_reg;
            end
            if (ctrl.min_run && pend_reg && (!min_valid_reg || (rd_key_reg < min_reg))) begin
                min_next       = rd_key_reg;
                min_valid_next = 1'b1;
            end
            if (ctrl.capture_idx) begin
                hit_next     = index_ok;
                hit_val_next = index_ok ? rd_val_reg : '0;
            end
            if (ctrl.set_full) begin
                status_next = 1'b1;
            end
        end

        priority if (ctrl.clear_count) begin
            count_next = '0;
        end else if (ctrl.append) begin
            count_next = count_reg + CW'(1);
        end else if (ctrl.dec_count) begin
            count_next = count_reg - CW'(1);
        end else begin
            count_next = count_reg;
        end

        if (ctrl.result_load) begin
            rsp_next.found       = hit_reg;
            rsp_next.value_out   = hit_val_reg;
            rsp_next.entry_count = 9'(count_reg);
            rsp_next.status      = status_reg;
            if (req_reg.command == lkv_pkg::CMD_MIN_KEY) begin
                rsp_next.key_out = min_valid_reg ? min_reg : '1;
            end else begin
                rsp_next.key_out = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            pend_reg  <= 1'b0;
        end else begin
            count_reg <= count_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg       <= req_next;
        rsp_reg       <= rsp_next;
        ptr_reg       <= ptr_next;
        pend_idx_reg  <= pend_idx_next;
        hit_reg       <= hit_next;
        hit_val_reg   <= hit_val_next;
        min_reg       <= min_next;
        min_valid_reg <= min_valid_next;
        status_reg    <= status_next;
    end

    assign m_rsp = rsp_reg;

    `LKV_ASSERT_NEVER(a_count_range, count_reg > CW'(CAPACITY))
    `LKV_ASSERT_IMPL(a_append_not_full, ctrl.append, count_reg < CW'(CAPACITY))
    `LKV_ASSERT_IMPL(a_shift_above_zero, ctrl.shift_write && pend_reg, pend_idx_reg != '0)

endmodule

### src/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// Command sequencer: handshakes, scan/shift/read sequencing and result hand-off.
// ----------------------------------------------------------------------------
`include "linear_key_value_table_defines.svh"

module lkv_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  logic [2:0]     s_command,
    output logic           m_valid,
    input  logic           m_ready,
    input  lkv_pkg::stat_t stat,
    output lkv_pkg::ctrl_t ctrl
);

    lkv_pkg::state_t state_reg, state_next;
    logic [2:0]      cmd_reg, cmd_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lkv_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg <= cmd_next;
    end

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        ctrl       = '0;
        s_ready    = 1'b0;

        unique case (state_reg)
            lkv_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    ctrl.latch       = 1'b1;
                    cmd_next         = s_command;
                    ctrl.clear_count = (s_command == lkv_pkg::CMD_CLEAR);
                    if (s_command == lkv_pkg::CMD_PUT || s_command == lkv_pkg::CMD_GET ||
                        s_command == lkv_pkg::CMD_REMOVE ||
                        s_command == lkv_pkg::CMD_MIN_KEY) begin
                        state_next = lkv_pkg::ST_SCAN;
                    end else if (s_command == lkv_pkg::CMD_READ_INDEX) begin
                        state_next = lkv_pkg::ST_RDIDX;
                    end else begin
                        state_next = lkv_pkg::ST_FINISH;
                    end
                end
            end
            lkv_pkg::ST_SCAN: begin
                ctrl.seq_run  = 1'b1;
                ctrl.min_run  = (cmd_reg == lkv_pkg::CMD_MIN_KEY);
                ctrl.take_hit = (cmd_reg == lkv_pkg::CMD_GET);
                if (stat.match && cmd_reg != lkv_pkg::CMD_MIN_KEY) begin
                    if (cmd_reg == lkv_pkg::CMD_PUT) begin
                        ctrl.put_update = 1'b1;
                        state_next      = lkv_pkg::ST_FINISH;
                    end else if (cmd_reg == lkv_pkg::CMD_REMOVE) begin
                        ctrl.shift_start = 1'b1;
                        state_next       = lkv_pkg::ST_SHIFT;
                    end else begin
                        state_next = lkv_pkg::ST_FINISH;
                    end
                end else if (stat.seq_end) begin
                    if (cmd_reg == lkv_pkg::CMD_PUT) begin
                        ctrl.set_full = stat.full;
                        ctrl.append   = !stat.full;
                    end
                    state_next = lkv_pkg::ST_FINISH;
                end
            end
            lkv_pkg::ST_SHIFT: begin
                ctrl.seq_run     = 1'b1;
                ctrl.shift_write = 1'b1;
                if (stat.seq_end) begin
                    ctrl.dec_count = 1'b1;
                    state_next     = lkv_pkg::ST_FINISH;
                end
            end
            lkv_pkg::ST_RDIDX: begin
                ctrl.rd_index = 1'b1;
                state_next    = lkv_pkg::ST_RDWAIT;
            end
            lkv_pkg::ST_RDWAIT: begin
                ctrl.capture_idx = 1'b1;
                state_next       = lkv_pkg::ST_FINISH;
            end
            lkv_pkg::ST_FINISH: begin
                // wait for the output register to drain
                if (!out_valid_reg || m_ready) begin
                    ctrl.result_load = 1'b1;
                    state_next       = lkv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        if (ctrl.result_load) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    assign m_valid = out_valid_reg;

    `LKV_ASSERT_NEXT(a_load_shows_result, ctrl.result_load, m_valid)
    `LKV_ASSERT_NEXT(a_latch_leaves_idle, ctrl.latch, state_reg != lkv_pkg::ST_IDLE)
    `LKV_ASSERT_NEXT(a_result_held, m_valid && !m_ready, m_valid)

endmodule

### src/linear_key_value_table.sv
// ----------------------------------------------------------------------------
// linear_key_value_table
// Unsorted key/value table of up to CAPACITY entries with linear search.
// ----------------------------------------------------------------------------
// Requests arrive on s_valid/s_ready with s_req (command, key, value, index);
// each request gives exactly one response on m_valid/m_ready with m_rsp.
// One request is worked on at a time. The scan reads one entry per cycle from
// the key/value RAM through its registered read port. Put, get and min_key
// scan the stored entries (a hit ends the scan early for put and get); a
// remove that hits scans to the hit, then shifts the later entries down one
// per cycle; read_by_index reads the RAM once, and clear and unused codes go
// straight to the finish step. The next request is accepted in the cycle
// after the response is loaded. The RAM read port sets the pace: one entry
// per cycle.
// A response sits in an output register; the next request is accepted while
// it waits, and the block stalls only its own finish step until m_ready.
// Reset empties the table at once (count cleared; RAM contents are not
// touched and are never read before being written). A full table drops a new
// key on put and reports status 1.
// ----------------------------------------------------------------------------
module linear_key_value_table #(
    parameter int CAPACITY = 256
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  lkv_pkg::req_t s_req,
    output logic          m_valid,
    input  logic          m_ready,
    output lkv_pkg::rsp_t m_rsp
);

    lkv_pkg::ctrl_t ctrl;
    lkv_pkg::stat_t stat;

    lkv_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_command (s_req.command),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    lkv_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_req   (s_req),
        .ctrl    (ctrl),
        .stat    (stat),
        .m_rsp   (m_rsp)
    );

endmodule
